// ===== src/bal_pkg.sv =====
// ----------------------------------------------------------------------------
// Bounded array list package
// Shared types and codes for the list controller, datapath and top level.
// ----------------------------------------------------------------------------
package bal_pkg;

   localparam logic [2:0] OP_APPEND = 3'd0;
   localparam logic [2:0] OP_READ   = 3'd1;
   localparam logic [2:0] OP_WRITE  = 3'd2;
   localparam logic [2:0] OP_REMOVE = 3'd3;
   localparam logic [2:0] OP_SWAP   = 3'd4;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   typedef struct packed {
      logic [2:0]         operation;
      logic [7:0]         index;
      logic [7:0]         second_index;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic [8:0]         count;
      logic [1:0]         status;
   } rsp_type;

   typedef enum logic [2:0] {
      WA_COUNT,
      WA_REQ,
      WA_HOLD_A,
      WA_HOLD_B,
      WA_SHIFT
   } wa_type;

   typedef enum logic [1:0] {
      WD_VALUE,
      WD_RDA,
      WD_RDB
   } wd_type;

   typedef enum logic {
      RA_REQ,
      RA_PTR
   } ra_type;

   typedef enum logic [1:0] {
      RV_ZERO,
      RV_RDA,
      RV_RES
   } rv_type;

   typedef struct packed {
      logic       mem_wr;
      wa_type     wr_addr;
      wd_type     wr_data;
      logic       rd_en;
      ra_type     rd_src;
      logic       ptr_load;
      logic       res_load;
      logic       count_inc;
      logic       count_dec;
      logic       rsp_load;
      rv_type     rsp_val;
      logic [1:0] status;
   } cmd_type;

   typedef struct packed {
      logic range_a;
      logic range_b;
      logic full;
      logic ptr_more;
   } stat_type;

endpackage

// ===== src/bal_dpath.sv =====
// ----------------------------------------------------------------------------
// Bounded array list datapath
// Entry memory with two registered read ports, live count, shift pointer and
// result assembly.
// ----------------------------------------------------------------------------
module bal_dpath #(
   parameter int CAPACITY = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  bal_pkg::req_type  req_data,
   input  bal_pkg::cmd_type  cmd,
   output bal_pkg::stat_type stat,
   output bal_pkg::rsp_type  rsp_out
);

   localparam int AW    = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > 9) ? CNT_W : 9;

   logic signed [31:0] mem [CAPACITY];

   logic signed [31:0] rda_ff;
   logic signed [31:0] rdb_ff;
   logic signed [31:0] res_ff;
   logic [AW-1:0]      hold_a_ff;
   logic [AW-1:0]      hold_b_ff;
   logic [CNT_W-1:0]   ptr_ff;
   logic [CNT_W-1:0]   ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic [CNT_W-1:0]   shift_pos;
   logic [CMP_W-1:0]   idx_a;
   logic [CMP_W-1:0]   idx_b;
   logic [CMP_W-1:0]   cnt_ext;
   logic [CMP_W-1:0]   cnt_next_ext;
   logic [AW-1:0]      rd_addr_a;
   logic [AW-1:0]      rd_addr_b;
   logic [AW-1:0]      wr_addr;
   logic signed [31:0] wr_data;

   assign idx_a        = CMP_W'(req_data.index);
   assign idx_b        = CMP_W'(req_data.second_index);
   assign cnt_ext      = CMP_W'(count_ff);
   assign shift_pos    = ptr_ff - CNT_W'(2);

   assign stat.range_a  = (idx_a >= cnt_ext);
   assign stat.range_b  = (idx_b >= cnt_ext);
   assign stat.full     = (count_ff == CNT_W'(CAPACITY));
   assign stat.ptr_more = (ptr_ff < count_ff);

   assign rd_addr_a = (cmd.rd_src == bal_pkg::RA_REQ) ? idx_a[AW-1:0] : ptr_ff[AW-1:0];
   assign rd_addr_b = idx_b[AW-1:0];

   always_comb begin
      case (cmd.wr_addr)
         bal_pkg::WA_COUNT:  wr_addr = count_ff[AW-1:0];
         bal_pkg::WA_REQ:    wr_addr = idx_a[AW-1:0];
         bal_pkg::WA_HOLD_A: wr_addr = hold_a_ff;
         bal_pkg::WA_HOLD_B: wr_addr = hold_b_ff;
         bal_pkg::WA_SHIFT:  wr_addr = shift_pos[AW-1:0];
         default:            wr_addr = count_ff[AW-1:0];
      endcase
   end

   always_comb begin
      case (cmd.wr_data)
         bal_pkg::WD_VALUE: wr_data = req_data.value;
         bal_pkg::WD_RDA:   wr_data = rda_ff;
         bal_pkg::WD_RDB:   wr_data = rdb_ff;
         default:           wr_data = req_data.value;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rda_ff <= mem[rd_addr_a];
         rdb_ff <= mem[rd_addr_b];
      end
   end

   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.ptr_load) begin
         ptr_in = CNT_W'(idx_a + CMP_W'(1));
      end else if (cmd.rd_en && (cmd.rd_src == bal_pkg::RA_PTR)) begin
         ptr_in = ptr_ff + CNT_W'(1);
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.count_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      if (cmd.rd_en && (cmd.rd_src == bal_pkg::RA_REQ)) begin
         hold_a_ff <= idx_a[AW-1:0];
         hold_b_ff <= idx_b[AW-1:0];
      end
      if (cmd.res_load) begin
         res_ff <= rda_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign cnt_next_ext = CMP_W'(count_in);

   always_comb begin
      case (cmd.rsp_val)
         bal_pkg::RV_ZERO: rsp_out.read_value = '0;
         bal_pkg::RV_RDA:  rsp_out.read_value = rda_ff;
         bal_pkg::RV_RES:  rsp_out.read_value = res_ff;
         default:          rsp_out.read_value = '0;
      endcase
      rsp_out.count  = cnt_next_ext[8:0];
      rsp_out.status = cmd.status;
   end

endmodule

// ===== src/bal_ctrl.sv =====
// ----------------------------------------------------------------------------
// Bounded array list controller
// Sequences each operation through memory reads, writes and the remove shift.
// ----------------------------------------------------------------------------
module bal_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [2:0]        operation,
   input  logic              rsp_free,
   input  bal_pkg::stat_type stat,
   output logic              req_ready,
   output bal_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_SWAP_A,
      S_SWAP_B,
      S_REM_FIRST,
      S_SHIFT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_ready = (state_ff == S_IDLE) && rsp_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.rsp_load = 1'b1;
               cmd.status   = bal_pkg::ST_OK;
               case (operation)
                  bal_pkg::OP_APPEND: begin
                     if (stat.full) begin
                        cmd.status = bal_pkg::ST_FULL;
                     end else begin
                        cmd.mem_wr    = 1'b1;
                        cmd.wr_addr   = bal_pkg::WA_COUNT;
                        cmd.wr_data   = bal_pkg::WD_VALUE;
                        cmd.count_inc = 1'b1;
                     end
                  end
                  bal_pkg::OP_READ: begin
                     if (stat.range_a) begin
                        cmd.status = bal_pkg::ST_RANGE;
                     end else begin
                        cmd.rsp_load = 1'b0;
                        cmd.rd_en    = 1'b1;
                        cmd.rd_src   = bal_pkg::RA_REQ;
                        state_in     = S_READ;
                     end
                  end
                  bal_pkg::OP_WRITE: begin
                     if (stat.range_a) begin
                        cmd.status = bal_pkg::ST_RANGE;
                     end else begin
                        cmd.mem_wr  = 1'b1;
                        cmd.wr_addr = bal_pkg::WA_REQ;
                        cmd.wr_data = bal_pkg::WD_VALUE;
                     end
                  end
                  bal_pkg::OP_REMOVE: begin
                     if (stat.range_a) begin
                        cmd.status = bal_pkg::ST_RANGE;
                     end else begin
                        cmd.rsp_load = 1'b0;
                        cmd.rd_en    = 1'b1;
                        cmd.rd_src   = bal_pkg::RA_REQ;
                        cmd.ptr_load = 1'b1;
                        state_in     = S_REM_FIRST;
                     end
                  end
                  bal_pkg::OP_SWAP: begin
                     if (stat.range_a || stat.range_b) begin
                        cmd.status = bal_pkg::ST_RANGE;
                     end else begin
                        cmd.rsp_load = 1'b0;
                        cmd.rd_en    = 1'b1;
                        cmd.rd_src   = bal_pkg::RA_REQ;
                        state_in     = S_SWAP_A;
                     end
                  end
                  default: begin
                     cmd.status = bal_pkg::ST_OK;
                  end
               endcase
            end
         end
         S_READ: begin
            cmd.rsp_load = 1'b1;
            cmd.rsp_val  = bal_pkg::RV_RDA;
            state_in     = S_IDLE;
         end
         S_SWAP_A: begin
            cmd.mem_wr  = 1'b1;
            cmd.wr_addr = bal_pkg::WA_HOLD_A;
            cmd.wr_data = bal_pkg::WD_RDB;
            state_in    = S_SWAP_B;
         end
         S_SWAP_B: begin
            cmd.mem_wr   = 1'b1;
            cmd.wr_addr  = bal_pkg::WA_HOLD_B;
            cmd.wr_data  = bal_pkg::WD_RDA;
            cmd.rsp_load = 1'b1;
            state_in     = S_IDLE;
         end
         S_REM_FIRST: begin
            cmd.res_load = 1'b1;
            if (stat.ptr_more) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_src = bal_pkg::RA_PTR;
               state_in   = S_SHIFT;
            end else begin
               cmd.count_dec = 1'b1;
               cmd.rsp_load  = 1'b1;
               cmd.rsp_val   = bal_pkg::RV_RDA;
               state_in      = S_IDLE;
            end
         end
         S_SHIFT: begin
            cmd.mem_wr  = 1'b1;
            cmd.wr_addr = bal_pkg::WA_SHIFT;
            cmd.wr_data = bal_pkg::WD_RDA;
            if (stat.ptr_more) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_src = bal_pkg::RA_PTR;
            end else begin
               cmd.count_dec = 1'b1;
               cmd.rsp_load  = 1'b1;
               cmd.rsp_val   = bal_pkg::RV_RES;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/bounded_array_list.sv =====
// ----------------------------------------------------------------------------
// Bounded array list
// An ordered list of signed 32-bit values in a fixed store with a live count.
// ----------------------------------------------------------------------------
// Each request transaction carries one operation: append, read, write, remove
// or swap. Each yields exactly one response transaction with the value read
// or removed, the count after the operation and a status code.
// Append, write, refused operations and undefined codes finish in the cycle
// of acceptance and respond in the cycle after. Read and swap wait on the
// registered read of the entry memory. Remove reads the entry, then moves
// every later entry down one place, since the shift uses the single memory
// write port once per cycle.
// The response sits in an output register. A new request is taken while the
// previous response is still pending only if the receiver takes it in that
// same cycle; a stalled receiver holds the block in its idle state.
// Reset clears the count and the controller; stored entries are not cleared,
// and only entries below the count are ever read.
// ----------------------------------------------------------------------------
module bounded_array_list #(
   parameter int CAPACITY = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bal_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bal_pkg::rsp_type rsp_data
);

   bal_pkg::cmd_type  cmd;
   bal_pkg::stat_type stat;
   bal_pkg::rsp_type  rsp_next;
   bal_pkg::rsp_type  rsp_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic              rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   bal_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .operation (req_data.operation),
      .rsp_free  (rsp_free),
      .stat      (stat),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   bal_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_out  (rsp_next)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
